FILE: rtl/det_pkg.sv
// shared types and constants for the discovery entity table
package det_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 16;

  localparam int TYPE_W = 4;
  localparam int SLOT_W = 4;
  localparam int S_TDATA_W = 264;
  localparam int M_TDATA_W = 8;

  localparam logic [TYPE_W-1:0] REQ_AVAILABLE = 4'd0;
  localparam logic [TYPE_W-1:0] REQ_DEPARTING = 4'd1;
  localparam logic [TYPE_W-1:0] REQ_DISCOVER  = 4'd2;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_DISCOVER  = 3'd5,
    ST_UNKNOWN   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_APPLY,
    S_EMIT
  } state_t;

  // received message, entity id in the lowest bits
  typedef struct packed {
    logic [47:0] source_mac;
    logic [31:0] avail_index;
    logic [15:0] controller_caps;
    logic [15:0] listener_caps;
    logic [15:0] listener_sinks;
    logic [15:0] talker_caps;
    logic [15:0] talker_sources;
    logic [31:0] now_seconds;
    logic [4:0]  lifetime;
    logic [63:0] node_id;
  } req_t;

  localparam int REQ_W = $bits(req_t);

  typedef struct packed {
    logic [15:0] talker_sources;
    logic [15:0] talker_caps;
    logic [15:0] listener_sinks;
    logic [15:0] listener_caps;
    logic [15:0] controller_caps;
    logic [31:0] avail_index;
    logic [47:0] mac;
    logic [31:0] expiry;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic table_op;
    logic last_addr;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/det_ctrl.sv
// controller state machine for the discovery entity table
module det_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  det_pkg::stat_t stat,
  output det_pkg::cmd_t  cmd
);
  import det_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.table_op) begin
          state_next = S_APPLY;
        end else begin
          cmd.issue = 1'b1;
          if (stat.last_addr) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/det_datapath.sv
// datapath: request register, slot tables, scan compare and result register
module det_datapath #(
  parameter int TABLE_ENTRIES = det_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [det_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic [det_pkg::TYPE_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [det_pkg::M_TDATA_W-1:0]     m_tdata,
  input  det_pkg::cmd_t                     cmd,
  output det_pkg::stat_t                    stat
);
  import det_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_ENTRIES - 1);

  req_t              req;
  logic [TYPE_W-1:0] req_type;

  logic [63:0] id_mem [TABLE_ENTRIES];
  entry_t      entry_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] in_use;

  logic [IW-1:0] scan_addr;
  logic          chk_valid;
  logic [IW-1:0] chk_addr;
  logic [63:0]   id_rd;

  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;

  status_t       res_status;
  logic [IW-1:0] res_idx;
  logic          res_touch;

  status_t          apply_status;
  logic [IW-1:0]    apply_idx;
  logic             apply_touch;
  logic             wr_entry;
  logic             wr_id;
  logic             set_use;
  logic             clr_use;
  entry_t           new_entry;
  logic [31:0]      idx_wide;
  logic [SLOT_W-1:0] res_slot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req      <= req_t'(s_tdata[REQ_W-1:0]);
      req_type <= s_tuser;
    end
  end

  assign stat.table_op  = (req_type == REQ_AVAILABLE) || (req_type == REQ_DEPARTING);
  assign stat.last_addr = (scan_addr == LAST_ADDR);
  assign stat.out_free  = !m_tvalid || m_tready;

  // scan address and registered id read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= cmd.issue;
      if (cmd.load) begin
        scan_addr <= '0;
      end else if (cmd.issue) begin
        scan_addr <= scan_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr <= scan_addr;
    id_rd    <= id_mem[scan_addr];
    if (wr_id) begin
      id_mem[apply_idx] <= req.node_id;
    end
    if (wr_entry) begin
      entry_mem[apply_idx] <= new_entry;
    end
  end

  // first matching slot and first free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (chk_valid) begin
      if (in_use[chk_addr] && (id_rd == req.node_id) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= chk_addr;
      end
      if (!in_use[chk_addr] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_addr;
      end
    end
  end

  always_comb begin
    new_entry.talker_sources  = req.talker_sources;
    new_entry.talker_caps     = req.talker_caps;
    new_entry.listener_sinks  = req.listener_sinks;
    new_entry.listener_caps   = req.listener_caps;
    new_entry.controller_caps = req.controller_caps;
    new_entry.avail_index     = req.avail_index;
    new_entry.mac             = req.source_mac;
    new_entry.expiry          = req.now_seconds + {26'd0, req.lifetime, 1'b0};
  end

  always_comb begin
    apply_status = ST_UNKNOWN;
    apply_idx    = '0;
    apply_touch  = 1'b0;
    wr_entry     = 1'b0;
    wr_id        = 1'b0;
    set_use      = 1'b0;
    clr_use      = 1'b0;
    if (req_type == REQ_AVAILABLE) begin
      if (hit_found) begin
        apply_status = ST_UPDATED;
        apply_idx    = hit_idx;
        apply_touch  = 1'b1;
        wr_entry     = cmd.apply;
      end else if (free_found) begin
        apply_status = ST_ADDED;
        apply_idx    = free_idx;
        apply_touch  = 1'b1;
        wr_entry     = cmd.apply;
        wr_id        = cmd.apply;
        set_use      = cmd.apply;
      end else begin
        apply_status = ST_FULL;
      end
    end else if (req_type == REQ_DEPARTING) begin
      if (hit_found) begin
        apply_status = ST_REMOVED;
        apply_idx    = hit_idx;
        apply_touch  = 1'b1;
        clr_use      = cmd.apply;
      end else begin
        apply_status = ST_NOT_FOUND;
      end
    end else if (req_type == REQ_DISCOVER) begin
      apply_status = ST_DISCOVER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (set_use) begin
      in_use[apply_idx] <= 1'b1;
    end else if (clr_use) begin
      in_use[apply_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_status <= apply_status;
      res_idx    <= apply_idx;
      res_touch  <= apply_touch;
    end
  end

  assign idx_wide = 32'(res_idx);
  assign res_slot = res_touch ? idx_wide[SLOT_W-1:0] : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {1'b0, res_slot, res_status};
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transfer");

  a_hit_in_use: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && hit_found) |-> in_use[hit_idx])
    else $error("matched slot not in use");

  a_free_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && free_found) |-> !in_use[free_idx])
    else $error("free slot already in use");

  a_add_sets: assert property (@(posedge clk) disable iff (rst)
    set_use |=> in_use[$past(apply_idx)])
    else $error("added slot not marked in use");

endmodule

FILE: rtl/discovery_entity_table.sv
// top level of the discovery entity table
// available and departing messages pass a one-slot-per-cycle id scan over all
// TABLE_ENTRIES slots, then apply and emit; discover and unknown messages skip the
// scan; a new message is taken after the result is handed to the output register,
// which may still wait for its transfer
// synchronous reset clears all in-use flags at once; stored entries are not cleared
module discovery_entity_table #(
  parameter int TABLE_ENTRIES = det_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // node_id, lifetime, now_seconds, talker_sources, talker_caps, listener_sinks,
  // listener_caps, controller_caps, avail_index, source_mac, zero pad
  input  logic [det_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type
  input  logic [det_pkg::TYPE_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status, slot, zero pad
  output logic [det_pkg::M_TDATA_W-1:0] m_tdata
);
  import det_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  det_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  det_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
